// ===== design/tccs_pkg.sv =====
package tccs_pkg;

   localparam int COLS_DEFAULT       = 80;
   localparam int MAX_ROWS_DEFAULT   = 32;
   localparam int FIFO_DEPTH_DEFAULT = 4;

   localparam int ROW_W  = 5;
   localparam int COL_W  = 7;
   localparam int BYTE_W = 8;
   localparam int CFG_W  = 6;
   localparam int ACT_W  = 2;
   localparam int CSR_IDX_W = 1;

   localparam logic [ACT_W-1:0] ACT_PUT    = 2'd0;
   localparam logic [ACT_W-1:0] ACT_CURSOR = 2'd1;
   localparam logic [ACT_W-1:0] ACT_READ   = 2'd2;

   localparam logic [BYTE_W-1:0] CHR_BS    = 8'd8;
   localparam logic [BYTE_W-1:0] CHR_TAB   = 8'd9;
   localparam logic [BYTE_W-1:0] CHR_NL    = 8'd10;
   localparam logic [BYTE_W-1:0] CHR_CR    = 8'd13;
   localparam logic [BYTE_W-1:0] CHR_SPACE = 8'd32;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_IN_USE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_OFFSET  = 1'b1;

   localparam logic [CFG_W-1:0] ROWS_RESET = 6'd25;

   typedef enum logic [2:0] {
      CMD_NOP,
      CMD_PUT,
      CMD_NEWLINE,
      CMD_TAB,
      CMD_BACKSPACE,
      CMD_CURSOR,
      CMD_READ
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [BYTE_W-1:0] char_code;
      logic              cursor_shown;
      logic [ROW_W-1:0]  read_row;
      logic [COL_W-1:0]  read_col;
   } cmd_type;

   typedef struct packed {
      logic              write_valid;
      logic [COL_W-1:0]  write_row;
      logic [COL_W-1:0]  write_col;
      logic [BYTE_W-1:0] write_byte;
      logic              scrolled;
      logic [ROW_W-1:0]  top_line;
      logic [ROW_W-1:0]  cursor_row_out;
      logic [COL_W-1:0]  cursor_col_out;
      logic [BYTE_W-1:0] read_byte;
   } rsp_fields_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_MEM,
      ST_RESP,
      ST_SCROLL
   } back_state_type;

endpackage

// ===== design/tccs_if.sv =====
interface tccs_req_if import tccs_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ACT_W-1:0]  action;
   logic [BYTE_W-1:0] char_code;
   logic              cursor_shown;
   logic [ROW_W-1:0]  read_row;
   logic [COL_W-1:0]  read_col;

   modport source (output valid, action, char_code, cursor_shown, read_row, read_col,
                   input ready);
   modport sink   (input valid, action, char_code, cursor_shown, read_row, read_col,
                   output ready);
endinterface

interface tccs_rsp_if import tccs_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              write_valid;
   logic [COL_W-1:0]  write_row;
   logic [COL_W-1:0]  write_col;
   logic [BYTE_W-1:0] write_byte;
   logic              scrolled;
   logic [ROW_W-1:0]  top_line;
   logic [ROW_W-1:0]  cursor_row_out;
   logic [COL_W-1:0]  cursor_col_out;
   logic [BYTE_W-1:0] read_byte;

   modport source (output valid, write_valid, write_row, write_col, write_byte, scrolled,
                          top_line, cursor_row_out, cursor_col_out, read_byte,
                   input ready);
   modport sink   (input valid, write_valid, write_row, write_col, write_byte, scrolled,
                         top_line, cursor_row_out, cursor_col_out, read_byte,
                   output ready);
endinterface

// ===== design/tccs_front.sv =====
module tccs_front import tccs_pkg::*; (
   tccs_req_if.sink req,
   input  logic     clearing,
   input  logic     fifo_full,
   output logic     push,
   output cmd_type  cmd
);

   assign req.ready = !fifo_full && !clearing;
   assign push      = req.valid && req.ready;

   always_comb begin
      cmd.char_code    = req.char_code;
      cmd.cursor_shown = req.cursor_shown;
      cmd.read_row     = req.read_row;
      cmd.read_col     = req.read_col;
      unique case (req.action)
         ACT_PUT: begin
            unique case (req.char_code)
               CHR_NL:  cmd.kind = CMD_NEWLINE;
               CHR_TAB: cmd.kind = CMD_TAB;
               CHR_CR:  cmd.kind = CMD_NOP;
               CHR_BS:  cmd.kind = CMD_BACKSPACE;
               default: cmd.kind = CMD_PUT;
            endcase
         end
         ACT_CURSOR: cmd.kind = CMD_CURSOR;
         ACT_READ:   cmd.kind = CMD_READ;
         default:    cmd.kind = CMD_NOP;
      endcase
   end

endmodule

// ===== design/tccs_fifo.sv =====
module tccs_fifo import tccs_pkg::*; #(
   parameter int DEPTH = FIFO_DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_data,
   output logic    empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type          entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/tccs_back.sv =====
module tccs_back import tccs_pkg::*; #(
   parameter int COLS     = COLS_DEFAULT,
   parameter int MAX_ROWS = MAX_ROWS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          fifo_data,
   input  logic             fifo_empty,
   output logic             fifo_pop,
   input  logic [CFG_W-1:0] rows,
   input  logic [CFG_W-1:0] row_offset,
   tccs_rsp_if.source       rsp,
   output logic             clearing
);

   localparam int DEPTH = MAX_ROWS * COLS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   back_state_type state_ff, state_in;

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_ff;

   logic [AW-1:0]     cnt_ff, cnt_in;
   logic [ROW_W-1:0]  top_ff, top_in;
   logic [ROW_W-1:0]  crow_ff, crow_in;
   logic [COL_W-1:0]  ccol_ff, ccol_in;
   logic              rsp_valid_ff, rsp_valid_in;

   cmd_type           cmd_ff;
   logic [ROW_W-1:0]  line_ff;
   logic [COL_W-1:0]  col_ff;
   logic              op_write_ff;
   logic [BYTE_W-1:0] wbyte_ff;
   rsp_fields_type    res_ff, res_in;
   logic              rd_wb_ff, rd_rb_ff;
   logic [ROW_W-1:0]  clr_line_ff;
   rsp_fields_type    rsp_data_ff, out_data;

   logic              mem_we, mem_re, out_load, out_free;
   logic [AW-1:0]     mem_addr;
   logic [BYTE_W-1:0] mem_wdata;

   // Item execution, from the normalized cursor and top line.
   logic              adv, ex_write, ex_wv, ex_sc, ex_rd_wb, ex_rd_rb;
   logic [ROW_W-1:0]  ex_row, ex_top, a_row, line_fin;
   logic [COL_W-1:0]  ex_col, a_col, col_fin;
   logic [BYTE_W-1:0] ex_byte;
   logic [CFG_W-1:0]  crow_inc, top_inc, line_sum, line_adj;
   logic [BYTE_W-1:0] col_inc, tab_col;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign crow_inc = {1'b0, crow_ff} + 6'd1;
   assign top_inc  = {1'b0, top_ff} + 6'd1;
   assign col_inc  = {1'b0, ccol_ff} + 8'd1;
   assign tab_col  = ({1'b0, ccol_ff} + 8'd4) & 8'hFC;

   always_comb begin
      adv      = 1'b0;
      ex_row   = crow_ff;
      ex_col   = ccol_ff;
      ex_top   = top_ff;
      ex_write = 1'b0;
      ex_wv    = 1'b0;
      ex_sc    = 1'b0;
      ex_rd_wb = 1'b0;
      ex_rd_rb = 1'b0;
      ex_byte  = cmd_ff.char_code;
      a_row    = crow_ff;
      a_col    = ccol_ff;
      case (cmd_ff.kind)
         CMD_NEWLINE: begin
            ex_col = '0;
            adv    = 1'b1;
         end
         CMD_TAB: begin
            if (tab_col >= 8'(COLS)) begin
               ex_col = '0;
               adv    = 1'b1;
            end else begin
               ex_col = tab_col[COL_W-1:0];
            end
         end
         CMD_PUT: begin
            ex_write = 1'b1;
            ex_wv    = 1'b1;
            if (col_inc >= 8'(COLS)) begin
               ex_col = '0;
               adv    = 1'b1;
            end else begin
               ex_col = col_inc[COL_W-1:0];
            end
         end
         CMD_BACKSPACE: begin
            // At the home position a backspace leaves everything as it is.
            if (ccol_ff != '0 || crow_ff != '0) begin
               if (ccol_ff == '0) begin
                  ex_row = crow_ff - 1'b1;
                  ex_col = COL_W'(COLS - 1);
               end else begin
                  ex_col = ccol_ff - 1'b1;
               end
               a_row    = ex_row;
               a_col    = ex_col;
               ex_write = 1'b1;
               ex_wv    = 1'b1;
               ex_byte  = CHR_SPACE;
            end
         end
         CMD_CURSOR: begin
            ex_wv    = 1'b1;
            ex_rd_wb = 1'b1;
         end
         CMD_READ: begin
            a_row    = cmd_ff.read_row;
            a_col    = cmd_ff.read_col;
            ex_rd_rb = ({1'b0, cmd_ff.read_row} < rows) && ({1'b0, cmd_ff.read_col} < 8'(COLS));
         end
         default: ;
      endcase
      if (adv) begin
         if (crow_inc >= rows) begin
            ex_sc  = 1'b1;
            ex_top = (top_inc >= rows) ? '0 : top_inc[ROW_W-1:0];
            ex_row = ROW_W'(rows - 6'd1);
         end else begin
            ex_row = crow_inc[ROW_W-1:0];
         end
      end
   end

   // Logical row to store line, through the circle of rows in use.
   always_comb begin
      line_sum = {1'b0, top_ff} + {1'b0, a_row};
      line_adj = (line_sum >= rows) ? line_sum - rows : line_sum;
      line_fin = (line_adj >= CFG_W'(MAX_ROWS)) ? '0 : line_adj[ROW_W-1:0];
      col_fin  = ({1'b0, a_col} >= 8'(COLS)) ? COL_W'(COLS - 1) : a_col;
   end

   always_comb begin
      res_in.write_valid    = ex_wv;
      res_in.write_row      = ex_wv ? COL_W'({2'b00, a_row} + {1'b0, row_offset}) : '0;
      res_in.write_col      = ex_wv ? a_col : '0;
      res_in.write_byte     = ex_wv ? ex_byte : '0;
      res_in.scrolled       = ex_sc;
      res_in.top_line       = ex_top;
      res_in.cursor_row_out = ex_row;
      res_in.cursor_col_out = ex_col;
      res_in.read_byte      = '0;
   end

   always_comb begin
      out_data = res_ff;
      if (rd_wb_ff) begin
         out_data.write_byte = rd_ff ^ {cmd_ff.cursor_shown, 7'b0};
      end
      if (rd_rb_ff) begin
         out_data.read_byte = rd_ff;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:  if (cnt_ff == AW'(DEPTH - 1)) state_in = ST_IDLE;
         ST_IDLE:   if (!fifo_empty) state_in = ST_EXEC;
         ST_EXEC:   state_in = ST_MEM;
         ST_MEM:    state_in = ST_RESP;
         ST_RESP: begin
            if (out_free) begin
               state_in = res_ff.scrolled ? ST_SCROLL : ST_IDLE;
            end
         end
         ST_SCROLL: if (cnt_ff == AW'(COLS - 1)) state_in = ST_IDLE;
         default:   state_in = ST_CLEAR;
      endcase
   end

   // Control outputs.
   always_comb begin
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_addr  = cnt_ff;
      mem_wdata = CHR_SPACE;
      fifo_pop  = 1'b0;
      out_load  = 1'b0;
      clearing  = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we   = 1'b1;
            clearing = 1'b1;
         end
         ST_IDLE:  fifo_pop = !fifo_empty;
         ST_EXEC:  ;
         ST_MEM: begin
            mem_we    = op_write_ff;
            mem_re    = !op_write_ff;
            mem_addr  = AW'(line_ff) * AW'(COLS) + AW'(col_ff);
            mem_wdata = wbyte_ff;
         end
         ST_RESP:  out_load = out_free;
         ST_SCROLL: begin
            mem_we   = 1'b1;
            mem_addr = AW'(clr_line_ff) * AW'(COLS) + cnt_ff;
         end
         default: ;
      endcase
   end

   // Control register next values.
   always_comb begin
      top_in  = top_ff;
      crow_in = crow_ff;
      ccol_in = ccol_ff;
      cnt_in  = cnt_ff;
      if (state_ff == ST_IDLE && fifo_pop) begin
         top_in  = ({1'b0, top_ff} >= rows) ? '0 : top_ff;
         crow_in = ({1'b0, crow_ff} >= rows) ? ROW_W'(rows - 6'd1) : crow_ff;
         ccol_in = ({1'b0, ccol_ff} >= 8'(COLS)) ? COL_W'(COLS - 1) : ccol_ff;
      end
      if (state_ff == ST_EXEC) begin
         top_in  = ex_top;
         crow_in = ex_row;
         ccol_in = ex_col;
      end
      if (state_ff == ST_CLEAR) begin
         cnt_in = (cnt_ff == AW'(DEPTH - 1)) ? '0 : cnt_ff + 1'b1;
      end
      if (state_ff == ST_SCROLL) begin
         cnt_in = (cnt_ff == AW'(COLS - 1)) ? '0 : cnt_ff + 1'b1;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         top_ff       <= '0;
         crow_ff      <= '0;
         ccol_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         top_ff       <= top_in;
         crow_ff      <= crow_in;
         ccol_ff      <= ccol_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fifo_pop) begin
         cmd_ff <= fifo_data;
      end
      if (state_ff == ST_EXEC) begin
         line_ff     <= line_fin;
         col_ff      <= col_fin;
         op_write_ff <= ex_write;
         wbyte_ff    <= ex_byte;
         res_ff      <= res_in;
         rd_wb_ff    <= ex_rd_wb;
         rd_rb_ff    <= ex_rd_rb;
         clr_line_ff <= top_ff;
      end
      if (out_load) begin
         rsp_data_ff <= out_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_ff <= mem[mem_addr];
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.write_valid    = rsp_data_ff.write_valid;
   assign rsp.write_row      = rsp_data_ff.write_row;
   assign rsp.write_col      = rsp_data_ff.write_col;
   assign rsp.write_byte     = rsp_data_ff.write_byte;
   assign rsp.scrolled       = rsp_data_ff.scrolled;
   assign rsp.top_line       = rsp_data_ff.top_line;
   assign rsp.cursor_row_out = rsp_data_ff.cursor_row_out;
   assign rsp.cursor_col_out = rsp_data_ff.cursor_col_out;
   assign rsp.read_byte      = rsp_data_ff.read_byte;

`ifndef SYNTHESIS
   a_no_rsp_while_clearing: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !rsp_valid_ff && !fifo_pop)
      else $error("result or queue pop during the clearing pass");

   a_cursor_col_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MEM |-> {1'b0, ccol_ff} < 8'(COLS))
      else $error("cursor column left the screen after execution");

   a_write_has_report: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MEM && op_write_ff |-> res_ff.write_valid)
      else $error("store write without a reported cell write");

   a_scroll_follows_report: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RESP && out_free && res_ff.scrolled |=>
         state_ff == ST_SCROLL && rsp_valid_ff && rsp_data_ff.scrolled)
      else $error("line clear without a scrolled result");
`endif

endmodule

// ===== design/text_console_cursor_scroll_unit.sv =====
// Text console with a cursor and a circular line store.
// req_chan carries one item per handshake: put a character, draw the cursor
// cell, or read one logical cell. rsp_chan returns exactly one result item
// for each request item, in order: the reported cell write, the scroll flag,
// the cursor and top line after the item, and the read byte.
// csr_wr_en with csr_index and csr_wdata writes rows_in_use or row_offset;
// write them only while no item is in flight.
// An item passes through the executor's dequeue, execute, store access
// and result load steps in order, and the executor finishes one item
// before it dequeues the next. An item that scrolls is followed by a
// line clear in which the COLS cells (80 by default) of the old top line
// are cleared to spaces, one cell a cycle. After reset all MAX_ROWS*COLS
// cells of the store (2560 by default) are swept to spaces;
// req_chan.ready stays low during that sweep.
// A short command queue sits between the decoder and the executor, and the
// result sits in an output register: when rsp_chan stalls, the executor
// holds its result and the queue keeps taking items until it is full.
module text_console_cursor_scroll_unit import tccs_pkg::*; #(
   parameter int COLS       = COLS_DEFAULT,
   parameter int MAX_ROWS   = MAX_ROWS_DEFAULT,
   parameter int FIFO_DEPTH = FIFO_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   tccs_req_if.sink             req_chan,
   tccs_rsp_if.source           rsp_chan,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   logic [CFG_W-1:0] rows_in_use_ff;
   logic [CFG_W-1:0] row_offset_ff;
   logic [CFG_W-1:0] rows_eff;

   logic    clearing, fifo_full, fifo_empty, push, pop;
   cmd_type push_cmd, pop_cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_in_use_ff <= ROWS_RESET;
         row_offset_ff  <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ROWS_IN_USE: rows_in_use_ff <= csr_wdata;
            CSR_ROW_OFFSET:  row_offset_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Zero rows behaves as one; more than the store holds is capped.
   always_comb begin
      if (rows_in_use_ff == '0) begin
         rows_eff = 6'd1;
      end else if (rows_in_use_ff > CFG_W'(MAX_ROWS)) begin
         rows_eff = CFG_W'(MAX_ROWS);
      end else begin
         rows_eff = rows_in_use_ff;
      end
   end

   tccs_front u_front (
      .req       (req_chan),
      .clearing  (clearing),
      .fifo_full (fifo_full),
      .push      (push),
      .cmd       (push_cmd)
   );

   tccs_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_cmd),
      .full      (fifo_full),
      .pop       (pop),
      .pop_data  (pop_cmd),
      .empty     (fifo_empty)
   );

   tccs_back #(
      .COLS     (COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .fifo_data  (pop_cmd),
      .fifo_empty (fifo_empty),
      .fifo_pop   (pop),
      .rows       (rows_eff),
      .row_offset (row_offset_ff),
      .rsp        (rsp_chan),
      .clearing   (clearing)
   );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import tccs_pkg::*;

   localparam int COLS          = COLS_DEFAULT;
   localparam int MAX_ROWS      = MAX_ROWS_DEFAULT;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = COLS + 20;
   localparam int MAX_GAP       = 40;
   localparam int BURST_LEN     = 20;
   localparam int PHASE_ITEMS   = 75;
   localparam int MAX_REPORTS   = 10;

   // The block treats action code 3 as a no-op.
   localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;
   typedef enum {TEXT_MIXED, TEXT_LONG, TEXT_LINES} text_style_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;

   tccs_req_if req_chan ();
   tccs_rsp_if rsp_chan ();

   text_console_cursor_scroll_unit #(
      .COLS     (COLS),
      .MAX_ROWS (MAX_ROWS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Shadow copy of the console state.
   logic [BYTE_W-1:0] screen_mem [0:MAX_ROWS*COLS-1];
   int                top_line_q;
   int                cur_row_q;
   int                cur_col_q;
   logic [CFG_W-1:0]  rows_cfg;
   logic [CFG_W-1:0]  offset_cfg;

   rsp_fields_type console_rsp_q[$];

   int err_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   int phase_rows [8] = '{1, 32, 0, 63, 3, 25, 2, 33};
   int phase_offs [8] = '{63, 0, 31, 1, 40, 0, 17, 62};

   function automatic int live_rows();
      int r;
      r = rows_cfg;
      if (r == 0) r = 1;
      if (r > MAX_ROWS) r = MAX_ROWS;
      return r;
   endfunction

   function automatic int cell_addr(int row, int col, int rows);
      int line;
      line = top_line_q + row;
      if (line >= rows) line -= rows;
      if (line >= MAX_ROWS) line = 0;
      if (col >= COLS) col = COLS - 1;
      return line * COLS + col;
   endfunction

   // Step the cursor down a row; past the last row the old top line is blanked.
   function automatic logic advance_row(int rows);
      cur_row_q++;
      if (cur_row_q >= rows) begin
         for (int i = 0; i < COLS; i++) screen_mem[top_line_q * COLS + i] = CHR_SPACE;
         top_line_q++;
         if (top_line_q >= rows) top_line_q = 0;
         cur_row_q = rows - 1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic rsp_fields_type console_response(logic [ACT_W-1:0] act,
                                                       logic [BYTE_W-1:0] ch,
                                                       logic shown,
                                                       logic [ROW_W-1:0] rrow,
                                                       logic [COL_W-1:0] rcol);
      rsp_fields_type r;
      int             rows;
      int             addr;
      r = '0;
      rows = live_rows();
      if (top_line_q >= rows) top_line_q = 0;
      if (cur_row_q >= rows) cur_row_q = rows - 1;
      if (cur_col_q >= COLS) cur_col_q = COLS - 1;

      case (act)
         ACT_PUT: begin
            case (ch)
               CHR_NL: begin
                  cur_col_q = 0;
                  r.scrolled = advance_row(rows);
               end
               CHR_TAB: begin
                  cur_col_q = (cur_col_q + 4) & ~3;
                  if (cur_col_q >= COLS) begin
                     cur_col_q = 0;
                     r.scrolled = advance_row(rows);
                  end
               end
               CHR_CR: ;
               CHR_BS: begin
                  if (cur_col_q != 0 || cur_row_q != 0) begin
                     if (cur_col_q == 0) begin
                        cur_row_q--;
                        cur_col_q = COLS - 1;
                     end else begin
                        cur_col_q--;
                     end
                     screen_mem[cell_addr(cur_row_q, cur_col_q, rows)] = CHR_SPACE;
                     r.write_valid = 1'b1;
                     r.write_row   = COL_W'(cur_row_q + offset_cfg);
                     r.write_col   = COL_W'(cur_col_q);
                     r.write_byte  = CHR_SPACE;
                  end
               end
               default: begin
                  screen_mem[cell_addr(cur_row_q, cur_col_q, rows)] = ch;
                  r.write_valid = 1'b1;
                  r.write_row   = COL_W'(cur_row_q + offset_cfg);
                  r.write_col   = COL_W'(cur_col_q);
                  r.write_byte  = ch;
                  cur_col_q++;
                  if (cur_col_q >= COLS) begin
                     cur_col_q = 0;
                     r.scrolled = advance_row(rows);
                  end
               end
            endcase
         end
         ACT_CURSOR: begin
            addr = cell_addr(cur_row_q, cur_col_q, rows);
            r.write_valid = 1'b1;
            r.write_row   = COL_W'(cur_row_q + offset_cfg);
            r.write_col   = COL_W'(cur_col_q);
            r.write_byte  = screen_mem[addr] + (shown ? 8'd128 : 8'd0);
         end
         ACT_READ: begin
            if (rrow < rows && rcol < COLS) r.read_byte = screen_mem[cell_addr(rrow, rcol, rows)];
         end
         default: ;
      endcase

      r.top_line       = ROW_W'(top_line_q);
      r.cursor_row_out = ROW_W'(cur_row_q);
      r.cursor_col_out = COL_W'(cur_col_q);
      return r;
   endfunction

   task automatic send_item(input logic [ACT_W-1:0] act, input logic [BYTE_W-1:0] ch,
                            input logic shown, input logic [ROW_W-1:0] rrow,
                            input logic [COL_W-1:0] rcol);
      int gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.action       <= act;
      req_chan.char_code    <= ch;
      req_chan.cursor_shown <= shown;
      req_chan.read_row     <= rrow;
      req_chan.read_col     <= rcol;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      console_rsp_q.push_back(console_response(act, ch, shown, rrow, rcol));
   endtask

   task automatic put_char(input logic [BYTE_W-1:0] ch);
      send_item(ACT_PUT, ch, 1'($urandom), ROW_W'($urandom), COL_W'($urandom));
   endtask

   // Let every outstanding item finish, including a line clear after the last result.
   task automatic drain_console();
      req_chan.valid <= 1'b0;
      while (console_rsp_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_screen_config(input int rows, input int offs);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_ROWS_IN_USE;
      csr_wdata <= CFG_W'(rows);
      @(posedge clock);
      rows_cfg  = CFG_W'(rows);
      csr_index <= CSR_ROW_OFFSET;
      csr_wdata <= CFG_W'(offs);
      @(posedge clock);
      offset_cfg = CFG_W'(offs);
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_random_item(input text_style_type style);
      logic [ACT_W-1:0]  act;
      logic [BYTE_W-1:0] ch;
      logic              shown;
      logic [ROW_W-1:0]  rrow;
      logic [COL_W-1:0]  rcol;
      int                pick;
      ch    = BYTE_W'($urandom);
      shown = 1'($urandom);
      rrow  = ROW_W'($urandom);
      rcol  = COL_W'($urandom);
      pick  = $urandom_range(99);
      if (pick < 8) begin
         act = ACT_CURSOR;
      end else if (pick < 20) begin
         act = ACT_READ;
         // Mostly reads inside the visible screen, some anywhere.
         if ($urandom_range(3) != 0) begin
            rrow = ROW_W'($urandom_range(live_rows() - 1));
            rcol = COL_W'($urandom_range(COLS - 1));
         end
      end else if (pick < 23) begin
         act = ACT_UNUSED;
      end else begin
         act  = ACT_PUT;
         pick = $urandom_range(99);
         case (style)
            TEXT_LONG: begin
               if (pick < 6) ch = CHR_TAB;
               else if (pick < 10) ch = CHR_BS;
               else if (pick < 12) ch = CHR_CR;
            end
            TEXT_LINES: begin
               if (pick < 35) ch = CHR_NL;
               else if (pick < 45) ch = CHR_BS;
               else if (pick < 55) ch = CHR_TAB;
               else if (pick < 60) ch = CHR_CR;
            end
            default: begin
               if (pick < 15) ch = CHR_NL;
               else if (pick < 23) ch = CHR_TAB;
               else if (pick < 30) ch = CHR_BS;
               else if (pick < 34) ch = CHR_CR;
            end
         endcase
      end
      send_item(act, ch, shown, rrow, rcol);
   endtask

   task automatic test_directed_basics();
      send_item(ACT_PUT, CHR_BS, 1'b0, '0, '0);     // backspace at home does nothing
      put_char(8'h41);
      put_char(8'h00);
      put_char(8'hFF);
      put_char(CHR_CR);
      put_char(CHR_TAB);
      send_item(ACT_CURSOR, 8'h00, 1'b0, '0, '0);
      send_item(ACT_CURSOR, 8'hFF, 1'b1, '1, '1);
      put_char(CHR_BS);
      send_item(ACT_READ, 8'h00, 1'b0, 5'd0, 7'd0);
      send_item(ACT_READ, 8'h00, 1'b0, 5'd0, 7'd2);
      send_item(ACT_READ, 8'h00, 1'b0, 5'd24, 7'd79);
      send_item(ACT_READ, 8'h00, 1'b0, 5'd25, 7'd0);
      send_item(ACT_READ, 8'hFF, 1'b1, 5'd31, 7'd127);
      send_item(ACT_READ, 8'h00, 1'b0, 5'd0, 7'd80);
      send_item(ACT_UNUSED, 8'hFF, 1'b1, '1, '1);
      put_char(CHR_NL);
      put_char(CHR_BS);        // steps back to the last column of the row above
      put_char(CHR_TAB);       // tab from the last column wraps to the next row
      put_char(CHR_BS);
      put_char(8'h5A);         // character in the last column wraps
      put_char(8'h7F);
   endtask

   task automatic test_scroll_and_overflow();
      put_char(8'hC8);
      put_char(CHR_NL);
      put_char(8'h71);
      drain_console();
      // Shrinking the screen pulls the cursor onto the high byte written above.
      apply_screen_config(2, 5);
      send_item(ACT_CURSOR, 8'h00, 1'b1, '0, '0);
      send_item(ACT_CURSOR, 8'h00, 1'b0, '0, '0);
      put_char(CHR_NL);
      send_item(ACT_READ, 8'h00, 1'b0, 5'd0, 7'd1);
      send_item(ACT_READ, 8'h00, 1'b0, 5'd1, 7'd0);
      drain_console();
      apply_screen_config(1, 63);
      put_char(CHR_BS);
      put_char(CHR_NL);
      put_char(8'h78);
      send_item(ACT_READ, 8'h00, 1'b0, 5'd1, 7'd0);
   endtask

   task automatic test_random_traffic(input idle_mode_type mode, input int first_phase);
      text_style_type style;
      style = TEXT_MIXED;
      case (mode)
         IDLE_SENDER:   begin send_idle_pct = 73; recv_stall_pct = 0;  end
         IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 73; end
         IDLE_BOTH:     begin send_idle_pct = 23; recv_stall_pct = 23; end
         default:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase
      for (int p = first_phase; p < first_phase + 2; p++) begin
         drain_console();
         apply_screen_config(phase_rows[p], phase_offs[p]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % BURST_LEN == 0) style = text_style_type'($urandom_range(2));
            send_random_item(style);
         end
      end
   endtask

   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin : check_results
      rsp_fields_type got;
      rsp_fields_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.write_valid    = rsp_chan.write_valid;
         got.write_row      = rsp_chan.write_row;
         got.write_col      = rsp_chan.write_col;
         got.write_byte     = rsp_chan.write_byte;
         got.scrolled       = rsp_chan.scrolled;
         got.top_line       = rsp_chan.top_line;
         got.cursor_row_out = rsp_chan.cursor_row_out;
         got.cursor_col_out = rsp_chan.cursor_col_out;
         got.read_byte      = rsp_chan.read_byte;
         if (console_rsp_q.size() == 0) begin
            if (err_count < MAX_REPORTS) $display("unexpected result item at cycle %0d", cycle_count);
            err_count++;
         end else begin
            want = console_rsp_q.pop_front();
            if (got !== want) begin
               if (err_count < MAX_REPORTS) begin
                  $display("mismatch at cycle %0d (wv row col byte scr top crow ccol rd)",
                           cycle_count);
                  $display("  expected %b %0d %0d %h %b %0d %0d %0d %h", want.write_valid,
                           want.write_row, want.write_col, want.write_byte, want.scrolled,
                           want.top_line, want.cursor_row_out, want.cursor_col_out,
                           want.read_byte);
                  $display("  actual   %b %0d %0d %h %b %0d %0d %0d %h", got.write_valid,
                           got.write_row, got.write_col, got.write_byte, got.scrolled,
                           got.top_line, got.cursor_row_out, got.cursor_col_out,
                           got.read_byte);
               end
               err_count++;
            end
         end
      end
   end

   initial begin
      req_chan.valid        = 1'b0;
      req_chan.action       = ACT_PUT;
      req_chan.char_code    = '0;
      req_chan.cursor_shown = 1'b0;
      req_chan.read_row     = '0;
      req_chan.read_col     = '0;
      csr_wr_en             = 1'b0;
      csr_index             = CSR_ROWS_IN_USE;
      csr_wdata             = '0;
      for (int i = 0; i < MAX_ROWS * COLS; i++) screen_mem[i] = CHR_SPACE;
      top_line_q = 0;
      cur_row_q  = 0;
      cur_col_q  = 0;
      rows_cfg   = ROWS_RESET;
      offset_cfg = '0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_directed_basics();
      test_scroll_and_overflow();
      test_random_traffic(IDLE_NONE, 0);
      test_random_traffic(IDLE_SENDER, 2);
      test_random_traffic(IDLE_RECEIVER, 4);
      test_random_traffic(IDLE_BOTH, 6);

      drain_console();
      if (err_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
